// ----- src/pqs_pkg.sv -----
// shared types and constants for the prompt queue serial command sender
package pqs_pkg;

   localparam int PROMPT_W = 16;
   localparam int BYTE_W   = 8;

   // item function codes
   localparam logic FUNC_PUSH = 1'b0;
   localparam logic FUNC_TICK = 1'b1;

   // frame bytes
   localparam logic [BYTE_W-1:0] FRAME_START  = 8'h7E;
   localparam logic [BYTE_W-1:0] FRAME_COUNT  = 8'h04;
   localparam logic [BYTE_W-1:0] FRAME_SELECT = 8'h03;
   localparam logic [BYTE_W-1:0] FRAME_END    = 8'hEF;

   // position of a byte within the frame
   localparam logic [2:0] BYTE_START  = 3'd0;
   localparam logic [2:0] BYTE_COUNT  = 3'd1;
   localparam logic [2:0] BYTE_SELECT = 3'd2;
   localparam logic [2:0] BYTE_HI     = 3'd3;
   localparam logic [2:0] BYTE_LO     = 3'd4;
   localparam logic [2:0] BYTE_LAST   = 3'd5;

   // position of a bit within one 8n1 character
   localparam logic [3:0] BIT_START = 4'd0;
   localparam logic [3:0] BIT_STOP  = 4'd9;

   typedef struct packed {
      logic                func;
      logic [PROMPT_W-1:0] prompt_number;
      logic                busy_req;
   } pqs_item_type;

   typedef struct packed {
      logic tx_line;
      logic active;
      logic frame_end;
   } pqs_result_type;

endpackage

// ----- src/pqs_if.sv -----
// request and response channel interfaces
interface pqs_req_if;
   logic                          valid;
   logic                          ready;
   logic                          func;
   logic [pqs_pkg::PROMPT_W-1:0]  prompt_number;
   logic                          busy_req;

   modport source (output valid, output func, output prompt_number, output busy_req,
                   input ready);
   modport sink (input valid, input func, input prompt_number, input busy_req,
                 output ready);
endinterface

interface pqs_rsp_if;
   logic valid;
   logic ready;
   logic tx_line;
   logic active;
   logic frame_end;

   modport source (output valid, output tx_line, output active, output frame_end,
                   input ready);
   modport sink (input valid, input tx_line, input active, input frame_end,
                 output ready);
endinterface

// ----- src/prompt_queue_serial_command_sender_top.sv -----
// top level of the prompt queue serial command sender
// Usage:
//   req_ch carries items: func 0 pushes prompt_number into the prompt ring
//   (stored as prompt_number + 1), func 1 is one serial bit time; busy_req
//   holds off bit times while the start byte of a frame is being sent.
//   rsp_ch returns one result per item: tx_line (line level after the item),
//   active (sender busy with frames) and frame_end (stop bit of the last byte).
//   csr_we/csr_wdata write the mute bit; while mute is set pushes are dropped.
// Timing and throughput:
//   a result is registered and presented in the cycle after its item transfers;
//   one item can transfer every cycle unless a held result stalls. The ring
//   memory is read every cycle at the next read pointer, so the next item's
//   entry is ready for it and a push to that entry is forwarded around the memory.
// Reset:
//   pointers, counters, mute and the output valid flag clear; the line returns
//   to mark. Ring contents are not cleared and need no clearing pass.
// Stall:
//   when rsp_ch is not ready and a result is held, req_ch.ready drops.
module prompt_queue_serial_command_sender_top #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   pqs_req_if.sink     req_ch,
   pqs_rsp_if.source   rsp_ch,
   input  logic        csr_we,
   input  logic        csr_wdata
);
   import pqs_pkg::*;

   logic           mute_ff, mute_in;
   logic           rsp_valid_ff, rsp_valid_in;
   pqs_result_type rsp_data_ff, rsp_data_in;
   pqs_result_type result;
   pqs_item_type   item;
   logic           req_xfer;

   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign req_xfer     = req_ch.valid && req_ch.ready;

   assign item = '{func: req_ch.func, prompt_number: req_ch.prompt_number,
                   busy_req: req_ch.busy_req};

   pqs_seq #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .item_valid (req_xfer),
      .item       (item),
      .mute       (mute_ff),
      .result     (result)
   );

   assign mute_in = csr_we ? csr_wdata : mute_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      priority if (req_xfer) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mute_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mute_ff      <= mute_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.tx_line   = rsp_data_ff.tx_line;
   assign rsp_ch.active    = rsp_data_ff.active;
   assign rsp_ch.frame_end = rsp_data_ff.frame_end;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ch.ready |-> !req_xfer)
      else $error("held result overwritten");

   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> rsp_valid_ff)
      else $error("transfer produced no result");

   a_push_no_frame_end: assert property (@(posedge clock) disable iff (reset)
      req_xfer && req_ch.func == FUNC_PUSH |=> !rsp_data_ff.frame_end)
      else $error("frame end on a push");
endmodule

// ----- src/pqs_ram.sv -----
// generic single-port-write, single-port-read ram with registered read
module pqs_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ----- src/pqs_seq.sv -----
// prompt ring pointers and 8n1 frame sequencer around the ring memory
module pqs_seq #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    item_valid,
   input  pqs_pkg::pqs_item_type   item,
   input  logic                    mute,
   output pqs_pkg::pqs_result_type result
);
   import pqs_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      return (p == PTR_LAST) ? '0 : p + PTR_W'(1);
   endfunction

   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [2:0]          byte_idx_ff, byte_idx_in;
   logic [3:0]          bit_idx_ff, bit_idx_in;
   logic                sending_ff, sending_in;
   logic                line_ff, line_in;
   logic                byp_ff, byp_in;
   logic [PROMPT_W-1:0] byp_data_ff, byp_data_in;

   logic                ram_we;
   logic [PROMPT_W-1:0] ram_wdata;
   logic [PROMPT_W-1:0] ram_rdata;
   logic [PROMPT_W-1:0] entry;
   logic [BYTE_W-1:0]   cur_byte;
   logic [2:0]          bit_sel;
   logic                fend;

   // ring entry at the read pointer; a push to that entry in the previous cycle is forwarded
   assign entry = byp_ff ? byp_data_ff : ram_rdata;

   always_comb begin
      unique case (byte_idx_ff)
         BYTE_START:  cur_byte = FRAME_START;
         BYTE_COUNT:  cur_byte = FRAME_COUNT;
         BYTE_SELECT: cur_byte = FRAME_SELECT;
         BYTE_HI:     cur_byte = entry[PROMPT_W-1:BYTE_W];
         BYTE_LO:     cur_byte = entry[BYTE_W-1:0];
         default:     cur_byte = FRAME_END;
      endcase
   end

   assign bit_sel   = 3'(bit_idx_ff - 4'd1);
   assign ram_wdata = item.prompt_number + PROMPT_W'(1);

   always_comb begin
      wr_ptr_in   = wr_ptr_ff;
      rd_ptr_in   = rd_ptr_ff;
      byte_idx_in = byte_idx_ff;
      bit_idx_in  = bit_idx_ff;
      sending_in  = sending_ff;
      line_in     = line_ff;
      ram_we      = 1'b0;
      fend        = 1'b0;
      if (item_valid) begin
         if (item.func == FUNC_PUSH) begin
            if (!mute) begin
               ram_we     = 1'b1;
               wr_ptr_in  = ptr_next(wr_ptr_ff);
               sending_in = 1'b1;
            end
         end else if (sending_ff && !(byte_idx_ff == BYTE_START && item.busy_req)) begin
            priority if (bit_idx_ff == BIT_START) begin
               line_in    = 1'b0;
               bit_idx_in = 4'd1;
            end else if (bit_idx_ff >= BIT_STOP) begin
               line_in    = 1'b1;
               bit_idx_in = BIT_START;
               if (byte_idx_ff == BYTE_LO) begin
                  rd_ptr_in = ptr_next(rd_ptr_ff);
               end
               if (byte_idx_ff >= BYTE_LAST) begin
                  fend        = 1'b1;
                  byte_idx_in = BYTE_START;
                  if (rd_ptr_ff == wr_ptr_ff) begin
                     sending_in = 1'b0;
                  end
               end else begin
                  byte_idx_in = byte_idx_ff + 3'd1;
               end
            end else begin
               line_in    = cur_byte[bit_sel];
               bit_idx_in = bit_idx_ff + 4'd1;
            end
         end
      end
   end

   // the memory is read at the next read pointer so the entry is ready for the next item
   assign byp_in      = ram_we && (wr_ptr_ff == rd_ptr_in);
   assign byp_data_in = ram_wdata;

   pqs_ram #(
      .WIDTH (PROMPT_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (wr_ptr_ff),
      .wr_data (ram_wdata),
      .rd_addr (rd_ptr_in),
      .rd_data (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         byte_idx_ff <= BYTE_START;
         bit_idx_ff  <= BIT_START;
         sending_ff  <= 1'b0;
         line_ff     <= 1'b1;
         byp_ff      <= 1'b0;
      end else begin
         wr_ptr_ff   <= wr_ptr_in;
         rd_ptr_ff   <= rd_ptr_in;
         byte_idx_ff <= byte_idx_in;
         bit_idx_ff  <= bit_idx_in;
         sending_ff  <= sending_in;
         line_ff     <= line_in;
         byp_ff      <= byp_in;
      end
   end

   always_ff @(posedge clock) begin
      byp_data_ff <= byp_data_in;
   end

   assign result = '{tx_line: line_in, active: sending_in, frame_end: fend};

   // idle sender sits at the frame start with the line at mark
   a_idle_at_rest: assert property (@(posedge clock) disable iff (reset)
      !sending_ff |-> (byte_idx_ff == BYTE_START && bit_idx_ff == BIT_START && line_ff))
      else $error("idle sender not at rest");

   a_frame_end_restart: assert property (@(posedge clock) disable iff (reset)
      item_valid && fend |=> (byte_idx_ff == BYTE_START && bit_idx_ff == BIT_START && line_ff))
      else $error("frame end did not return to start byte");

   a_bit_range: assert property (@(posedge clock) disable iff (reset)
      bit_idx_ff <= BIT_STOP && byte_idx_ff <= BYTE_LAST)
      else $error("bit or byte counter out of range");

   a_forward: assert property (@(posedge clock) disable iff (reset)
      ram_we && (wr_ptr_ff == rd_ptr_in) |=> entry == $past(ram_wdata))
      else $error("write to read entry not forwarded");

   a_push_only_write: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (item_valid && item.func == FUNC_PUSH && !mute))
      else $error("ring written without a push");
endmodule
